@@ design/mctb_pkg.sv @@
// mctb_pkg: shared types and codes for the multi-channel soft timer bank
// operation and status codes, the walking token and the slot command
// no dependencies
package mctb_pkg;

  localparam int SLOT_CAP = 16;
  localparam int IDX_W    = 4;
  localparam int TIME_W   = 32;

  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_ALLOC = 3'd1;
  localparam logic [2:0] MODE_FREE  = 3'd2;
  localparam logic [2:0] MODE_START = 3'd3;
  localparam logic [2:0] MODE_STOP  = 3'd4;
  localparam logic [2:0] MODE_SWEEP = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_UNALLOC  = 2'd3;

  // register index as decoded from the word-aligned byte address
  localparam logic REG_ENABLE = 1'b0;

  // token handed from cell to cell during allocate and sweep
  typedef struct packed {
    logic valid;
    logic alloc;
    logic claimed;
  } tok_t;

  // single-slot command for free, start and stop
  typedef struct packed {
    logic              valid;
    logic [2:0]        op;
    logic [IDX_W-1:0]  index;
    logic [TIME_W-1:0] ticks;
    logic              periodic;
  } cmd_t;

  typedef struct packed {
    logic alloc_hit;
    logic sweep_hit;
  } evt_t;

endpackage

@@ design/mctb_cell.sv @@
// mctb_cell: one timer slot of the chain, with its own expiry compare
// passes the token to the next cell each cycle; uses mctb_pkg
module mctb_cell import mctb_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [TIME_W-1:0] time_base,
  input  tok_t              tok_in,
  output tok_t              tok_out,
  output evt_t              evt,
  output logic              allocated
);

  logic              running;
  logic              periodic;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] target;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              sel;
  tok_t              tok_next;

  assign sel     = cmd.valid && (cmd.index == IDX_W'(IDX));
  assign elapsed = time_base - start_time;
  assign due     = running && (elapsed >= target);

  assign evt.sweep_hit = tok_in.valid && !tok_in.alloc && due;
  assign evt.alloc_hit = tok_in.valid && tok_in.alloc && !tok_in.claimed && !allocated;

  always_comb begin
    tok_next         = tok_in;
    tok_next.claimed = tok_in.claimed || evt.alloc_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out   <= '0;
      allocated <= 1'b0;
      running   <= 1'b0;
      periodic  <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (evt.alloc_hit) begin
        allocated <= 1'b1;
        running   <= 1'b0;
        periodic  <= 1'b0;
      end else if (evt.sweep_hit) begin
        if (!periodic) begin
          running <= 1'b0;
        end
      end else if (sel) begin
        case (cmd.op)
          MODE_FREE: begin
            allocated <= 1'b0;
            running   <= 1'b0;
            periodic  <= 1'b0;
          end
          MODE_START: begin
            running  <= 1'b1;
            periodic <= cmd.periodic;
          end
          MODE_STOP: begin
            running  <= 1'b0;
            periodic <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // time fields, only read while the slot runs
  always_ff @(posedge clk) begin
    if (evt.sweep_hit && periodic) begin
      start_time <= time_base;
    end else if (!evt.alloc_hit && !evt.sweep_hit && sel) begin
      case (cmd.op)
        MODE_FREE: begin
          start_time <= '0;
          target     <= '0;
        end
        MODE_START: begin
          start_time <= time_base;
          target     <= cmd.ticks;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/multi_channel_soft_timer_bank.sv @@
// multi_channel_soft_timer_bank: tick, free, start and stop are handled directly from idle;
// the result strobe follows in the cycle after the transfer, and start is taken again at once.
// allocate and sweep walk a token down the slot chain, one slot per cycle:
// busy while the token crosses min(NUM_TIMERS,16) slots; the final result strobe rises as busy falls.
// sweep results come out one per expired slot, each one held until the next is found.
// synchronous reset clears time base, all slots and enable; uses mctb_pkg and mctb_cell
module multi_channel_soft_timer_bank import mctb_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [3:0]  timer_index,
  input  logic [31:0] tick_count,
  input  logic        periodic,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  slot_index,
  output logic        expired,
  output logic        last
);

  localparam int SLOT_COUNT = (NUM_TIMERS < SLOT_CAP) ? NUM_TIMERS : SLOT_CAP;

  typedef enum logic {IDLE, WALK} state_t;

  state_t                  state;
  logic                    enable;
  logic [TIME_W-1:0]       time_base;
  tok_t                    inject;
  tok_t                    tok_chain [SLOT_COUNT+1];
  evt_t                    evts [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   alloc_bits;
  logic [SLOT_COUNT-1:0]   alloc_hits;
  logic [SLOT_COUNT-1:0]   sweep_hits;
  logic [SLOT_COUNT-1:0]   tok_valid;
  logic [SLOT_CAP-1:0]     alloc_pad;
  logic                    slot_ok;
  logic                    accept;
  logic                    is_alloc;
  logic [IDX_W-1:0]        pos;
  logic [IDX_W-1:0]        pend;
  logic                    pend_v;
  cmd_t                    cmd;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ENABLE)) begin
      enable <= pwdata[0];
    end
  end

  assign busy   = (state == WALK);
  assign accept = start && !busy;

  assign alloc_pad = SLOT_CAP'(alloc_bits);
  assign slot_ok   = alloc_pad[timer_index];

  always_comb begin
    cmd.valid    = accept && enable && slot_ok &&
                   (mode == MODE_FREE || mode == MODE_START || mode == MODE_STOP);
    cmd.op       = mode;
    cmd.index    = timer_index;
    cmd.ticks    = tick_count;
    cmd.periodic = periodic;
  end

  // slot chain
  assign tok_chain[0] = inject;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    mctb_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .time_base (time_base),
      .tok_in    (tok_chain[i]),
      .tok_out   (tok_chain[i+1]),
      .evt       (evts[i]),
      .allocated (alloc_bits[i])
    );
    assign alloc_hits[i] = evts[i].alloc_hit;
    assign sweep_hits[i] = evts[i].sweep_hit;
    assign tok_valid[i]  = tok_chain[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      done      <= 1'b0;
      inject    <= '0;
      pend_v    <= 1'b0;
      time_base <= '0;
    end else begin
      done   <= 1'b0;
      inject <= '0;
      case (state)
        IDLE: begin
          if (start) begin
            done       <= 1'b1;
            status     <= ST_OK;
            slot_index <= '0;
            expired    <= 1'b0;
            last       <= 1'b1;
            if (!enable) begin
              status <= ST_DISABLED;
            end else begin
              case (mode)
                MODE_TICK: begin
                  time_base <= time_base + 1'b1;
                end
                MODE_ALLOC, MODE_SWEEP: begin
                  done     <= 1'b0;
                  state    <= WALK;
                  inject   <= '{valid: 1'b1, alloc: (mode == MODE_ALLOC), claimed: 1'b0};
                  is_alloc <= (mode == MODE_ALLOC);
                  pos      <= '0;
                  pend_v   <= 1'b0;
                end
                MODE_FREE, MODE_START, MODE_STOP: begin
                  if (!slot_ok) begin
                    status <= ST_UNALLOC;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        WALK: begin
          pos <= pos + 1'b1;
          if (is_alloc) begin
            if (|alloc_hits) begin
              pend   <= pos;
              pend_v <= 1'b1;
            end
          end else if (|sweep_hits) begin
            if (pend_v) begin
              done       <= 1'b1;
              status     <= ST_OK;
              slot_index <= pend;
              expired    <= 1'b1;
              last       <= 1'b0;
            end
            pend   <= pos;
            pend_v <= 1'b1;
          end
          if (tok_chain[SLOT_COUNT].valid) begin
            state      <= IDLE;
            done       <= 1'b1;
            status     <= (is_alloc && !pend_v) ? ST_FULL : ST_OK;
            slot_index <= pend_v ? pend : '0;
            expired    <= !is_alloc && pend_v;
            last       <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    accept && (!enable || (mode != MODE_ALLOC && mode != MODE_SWEEP)) |=> done && last)
    else $error("one-cycle operation gave no final result");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one token in the slot chain");

  a_expired_ok: assert property (@(posedge clk) disable iff (rst)
    done && expired |-> status == ST_OK && !(busy && is_alloc))
    else $error("expiry reported with bad status");

  a_alloc_quiet: assert property (@(posedge clk) disable iff (rst)
    busy && is_alloc |-> !done)
    else $error("result during allocate walk");

endmodule
